FILE: rtl/fqp_pkg.sv
// ----------------------------------------------------------------------------
// fqp_pkg
// Shared types and constants of the FASTA/FASTQ record parser.
// ----------------------------------------------------------------------------
package fqp_pkg;

    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_AT = 8'h40;
    localparam logic [7:0] CH_NL = 8'h0A;

    localparam int unsigned LEN_WIDTH   = 32;
    localparam int unsigned TDATA_WIDTH = 48;

    typedef enum logic [2:0] {
        KIND_NAME = 3'd0,
        KIND_BASE = 3'd1,
        KIND_QUAL = 3'd2,
        KIND_END  = 3'd3,
        KIND_ERR  = 3'd4
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [7:0]           value;
        logic                 record_format;
        logic [LEN_WIDTH-1:0] record_length;
        logic                 length_mismatch;
    } result_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_input;
    } item_t;

endpackage

FILE: rtl/fqp_in_stage.sv
// ----------------------------------------------------------------------------
// fqp_in_stage
// Input register: holds one accepted byte item until the parser takes it.
// ----------------------------------------------------------------------------
module fqp_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  fqp_pkg::item_t in_item,
    output logic          item_valid,
    input  logic          item_take,
    output fqp_pkg::item_t item
);
    import fqp_pkg::*;

    logic  vld_reg;
    item_t item_reg;

    assign in_ready   = !vld_reg || item_take;
    assign item_valid = vld_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

FILE: rtl/fqp_core.sv
// ----------------------------------------------------------------------------
// fqp_core
// Parse state machine with base and quality counters; one byte per transfer.
// ----------------------------------------------------------------------------
module fqp_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  fqp_pkg::item_t  item,
    output logic            res_valid,
    output fqp_pkg::result_t res
);
    import fqp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FA_NAME, ST_FA_SEQ, ST_FQ_NAME,
        ST_FQ_SEQ, ST_FQ_SKIP, ST_FQ_QUAL, ST_HALT
    } state_t;

    state_t                 state_reg, state_next;
    logic [COUNT_WIDTH-1:0] base_reg, base_next;
    logic [COUNT_WIDTH-1:0] qual_reg, qual_next;
    logic [LEN_WIDTH-1:0]   len_sat;
    logic [COUNT_WIDTH-1:0] base_inc, qual_inc;
    logic                   eol;
    logic                   fastq;

    generate
        if (COUNT_WIDTH > LEN_WIDTH)
        begin : g_wide
            assign len_sat = (|base_reg[COUNT_WIDTH-1:LEN_WIDTH]) ?
                             {LEN_WIDTH{1'b1}} : base_reg[LEN_WIDTH-1:0];
        end
        else
        begin : g_narrow
            assign len_sat = LEN_WIDTH'(base_reg);
        end
    endgenerate

    assign base_inc = (&base_reg) ? base_reg : base_reg + 1'b1;
    assign qual_inc = (&qual_reg) ? qual_reg : qual_reg + 1'b1;
    assign eol      = (item.byte_in == CH_NL) || (item.byte_in == 8'h00);
    assign fastq    = (state_reg == ST_FQ_NAME) || (state_reg == ST_FQ_SEQ) ||
                      (state_reg == ST_FQ_SKIP) || (state_reg == ST_FQ_QUAL);

    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        qual_next  = qual_reg;
        res_valid  = 1'b0;
        res        = '0;
        res.kind   = KIND_NAME;
        if (take)
        begin
            if (state_reg == ST_IDLE)
            begin
                if (!item.end_of_input && item.byte_in != CH_NL)
                begin
                    base_next = '0;
                    qual_next = '0;
                    if (item.byte_in == CH_GT)
                    begin
                        state_next = ST_FA_NAME;
                    end
                    else if (item.byte_in == CH_AT)
                    begin
                        state_next = ST_FQ_NAME;
                    end
                    else
                    begin
                        state_next = ST_HALT;
                        res_valid  = 1'b1;
                        res.kind   = KIND_ERR;
                    end
                end
            end
            else if (state_reg != ST_HALT)
            begin
                if (item.end_of_input ||
                    (state_reg == ST_FA_SEQ && (item.byte_in == CH_GT ||
                                                item.byte_in == 8'h00)) ||
                    (state_reg == ST_FQ_QUAL && eol))
                begin
                    res_valid           = 1'b1;
                    res.kind            = KIND_END;
                    res.record_format   = fastq;
                    res.record_length   = len_sat;
                    res.length_mismatch = fastq && (base_reg != qual_reg);
                    base_next           = '0;
                    qual_next           = '0;
                    state_next          = (!item.end_of_input && state_reg == ST_FA_SEQ &&
                                           item.byte_in == CH_GT) ? ST_FA_NAME : ST_IDLE;
                end
                else
                begin
                    case (state_reg)
                        ST_FA_NAME, ST_FQ_NAME:
                        begin
                            if (eol)
                            begin
                                state_next = (state_reg == ST_FA_NAME) ? ST_FA_SEQ : ST_FQ_SEQ;
                            end
                            else
                            begin
                                res_valid = 1'b1;
                                res.kind  = KIND_NAME;
                                res.value = item.byte_in;
                            end
                        end
                        ST_FA_SEQ:
                        begin
                            if (item.byte_in != CH_NL)
                            begin
                                base_next = base_inc;
                                res_valid = 1'b1;
                                res.kind  = KIND_BASE;
                                res.value = item.byte_in;
                            end
                        end
                        ST_FQ_SEQ:
                        begin
                            if (eol)
                            begin
                                state_next = ST_FQ_SKIP;
                            end
                            else
                            begin
                                base_next = base_inc;
                                res_valid = 1'b1;
                                res.kind  = KIND_BASE;
                                res.value = item.byte_in;
                            end
                        end
                        ST_FQ_SKIP:
                        begin
                            if (eol)
                            begin
                                state_next = ST_FQ_QUAL;
                            end
                        end
                        ST_FQ_QUAL:
                        begin
                            qual_next = qual_inc;
                            res_valid = 1'b1;
                            res.kind  = KIND_QUAL;
                            res.value = item.byte_in;
                        end
                        default:
                        begin
                            state_next = state_reg;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            base_reg  <= '0;
            qual_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            qual_reg  <= qual_next;
        end
    end

endmodule

FILE: rtl/fqp_out_buf.sv
// ----------------------------------------------------------------------------
// fqp_out_buf
// Result register with a skid stage; ready toward the parser is registered.
// ----------------------------------------------------------------------------
module fqp_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  fqp_pkg::result_t push_res,
    output logic             can_push,
    output logic             out_valid,
    input  logic             out_ready,
    output fqp_pkg::result_t out_res
);
    import fqp_pkg::*;

    logic    main_vld_reg, skid_vld_reg;
    result_t main_reg, skid_reg;
    logic    pop;

    assign pop       = main_vld_reg && out_ready;
    assign can_push  = !skid_vld_reg;
    assign out_valid = main_vld_reg;
    assign out_res   = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (pop)
            begin
                skid_vld_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_vld_reg && !pop)
            begin
                skid_vld_reg <= 1'b1;
            end
            main_vld_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (main_vld_reg && !pop)
            begin
                skid_reg <= push_res;
            end
            else
            begin
                main_reg <= push_res;
            end
        end
    end

endmodule

FILE: rtl/fasta_fastq_record_parser.sv
// Path: input register, combinational parse state machine, output buffer register.
// One byte per cycle unless the output stalls, set by the parse state update.
// A stalled output fills the skid stage, then stops input after one more byte.
// Reset (rst_n, async, active low) returns the parser to idle with zero counts
// and clears all valid flags; a format error halts the parser until reset.
// ----------------------------------------------------------------------------
// fasta_fastq_record_parser
// Streaming FASTA/FASTQ parser: name, base, quality, record-end and error items.
// ----------------------------------------------------------------------------
module fasta_fastq_record_parser #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    input  logic        s_tuser,   // [0] end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [fqp_pkg::TDATA_WIDTH-1:0] m_tdata,
                                   // [7:0] value, [8] record_format,
                                   // [40:9] record_length, [41] length_mismatch
    output logic [2:0]  m_tuser    // [2:0] kind
);
    import fqp_pkg::*;

    item_t   in_item, item;
    logic    item_valid, take, can_push, res_valid;
    result_t res, out_res;

    assign in_item.byte_in      = s_tdata;
    assign in_item.end_of_input = s_tuser;
    assign take                 = item_valid && can_push;

    fqp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (take),
        .item       (item)
    );

    fqp_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    fqp_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_res  (res),
        .can_push  (can_push),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tuser = out_res.kind;
    assign m_tdata = {6'd0, out_res.length_mismatch, out_res.record_length,
                      out_res.record_format, out_res.value};

endmodule
